>>> rtl/cbpe_pkg.sv
// Shared types, constants and the step-to-parameter table of the Bezier point evaluator.
package cbpe_pkg;

  // Curve subdivision and field widths.
  localparam int SEGMENTS   = 100;
  localparam int STEP_W     = 11;
  localparam int IDX_W      = $clog2(SEGMENTS + 1);
  localparam int COORD_W    = 16;
  localparam int T_W        = 17;
  localparam int ONE_T      = 65536;
  localparam int SQ_W       = 2 * T_W - 1;
  localparam int W_W        = 3 * T_W - 2;
  localparam int PROD_W     = W_W + 1 + COORD_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int W_FRAC     = 48;
  localparam int HI_W       = ACC_W - W_FRAC;
  localparam int PIPE_DEPTH = 7;

  // Configuration port.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } cfg_reg_e;

  localparam logic [COORD_W-1:0] P0_X_RST = 16'd1600;
  localparam logic [COORD_W-1:0] P0_Y_RST = 16'd4800;
  localparam logic [COORD_W-1:0] P1_X_RST = 16'd4800;
  localparam logic [COORD_W-1:0] P1_Y_RST = 16'd8000;
  localparam logic [COORD_W-1:0] P2_X_RST = 16'd8000;
  localparam logic [COORD_W-1:0] P2_Y_RST = 16'd1600;
  localparam logic [COORD_W-1:0] P3_X_RST = 16'd11200;
  localparam logic [COORD_W-1:0] P3_Y_RST = 16'd4800;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W - W_FRAC){1'b0}}, 1'b1, {(W_FRAC - 1){1'b0}}};

  // Table of t = round(i / SEGMENTS) as an unsigned 1.16 fraction, built at elaboration.
  typedef logic [T_W-1:0] t_lut_t [SEGMENTS+1];

  function automatic t_lut_t build_t_lut();
    t_lut_t lut;
    for (int k = 0; k <= SEGMENTS; k++) begin
      lut[k] = T_W'((longint'(k) * ONE_T + SEGMENTS / 2) / SEGMENTS);
    end
    return lut;
  endfunction

  localparam t_lut_t T_LUT = build_t_lut();

  // Bernstein weights without the factor 3 on the middle terms, in units of 2^-48.
  typedef struct packed {
    logic [W_W-1:0] w0;
    logic [W_W-1:0] w1;
    logic [W_W-1:0] w2;
    logic [W_W-1:0] w3;
  } weights_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } weight_ctrl_t;

  typedef struct packed {
    logic s4_en;
    logic s5_en;
    logic s6_en;
    logic s7_en;
  } blend_ctrl_t;

endpackage

>>> rtl/cbpe_weight.sv
// Stages one to three: step clamp, parameter lookup, squares of t and u, then the four cubic products of t and u.
module cbpe_weight (
  input  logic                        clk_i,
  input  cbpe_pkg::weight_ctrl_t      ctrl_i,
  input  logic [cbpe_pkg::STEP_W-1:0] step_index_i,
  output cbpe_pkg::weights_t          weights_o
);
  import cbpe_pkg::*;

  logic [IDX_W-1:0]     idx;
  logic [T_W-1:0]       t_d, u_d;
  logic [T_W-1:0]       t1_q, u1_q, t2_q, u2_q;
  logic [2*T_W-1:0]     uu, tt;
  logic [SQ_W-1:0]      usq_q, tsq_q;
  logic [SQ_W+T_W-1:0]  c0, c1, c2, c3;
  weights_t             w_d, w_q;

  always_comb begin
    if (step_index_i >= STEP_W'(SEGMENTS)) begin
      idx = IDX_W'(SEGMENTS);
    end else begin
      idx = step_index_i[IDX_W-1:0];
    end
    t_d = T_LUT[idx];
    u_d = T_W'(ONE_T) - t_d;
  end

  assign uu = u1_q * u1_q;
  assign tt = t1_q * t1_q;

  assign c0 = usq_q * u2_q;
  assign c1 = usq_q * t2_q;
  assign c2 = tsq_q * u2_q;
  assign c3 = tsq_q * t2_q;

  always_comb begin
    w_d.w0 = c0[W_W-1:0];
    w_d.w1 = c1[W_W-1:0];
    w_d.w2 = c2[W_W-1:0];
    w_d.w3 = c3[W_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      t1_q <= t_d;
      u1_q <= u_d;
    end
    if (ctrl_i.s2_en) begin
      usq_q <= uu[SQ_W-1:0];
      tsq_q <= tt[SQ_W-1:0];
      t2_q  <= t1_q;
      u2_q  <= u1_q;
    end
    if (ctrl_i.s3_en) begin
      w_q <= w_d;
    end
  end

  assign weights_o = w_q;

endmodule

>>> rtl/cbpe_blend.sv
// Stages four to seven for one coordinate: weighted products, sum, rounding and saturation.
module cbpe_blend (
  input  logic                                clk_i,
  input  cbpe_pkg::blend_ctrl_t               ctrl_i,
  input  cbpe_pkg::weights_t                  weights_i,
  input  logic signed [cbpe_pkg::COORD_W-1:0] p0_i,
  input  logic signed [cbpe_pkg::COORD_W-1:0] p1_i,
  input  logic signed [cbpe_pkg::COORD_W-1:0] p2_i,
  input  logic signed [cbpe_pkg::COORD_W-1:0] p3_i,
  output logic signed [cbpe_pkg::COORD_W-1:0] point_o
);
  import cbpe_pkg::*;

  localparam logic signed [HI_W-1:0] HI_MAX =
    {{(HI_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [HI_W-1:0] HI_MIN =
    {{(HI_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

  logic signed [PROD_W-1:0]  pr0_d, pr1_d, pr2_d, pr3_d;
  logic signed [PROD_W-1:0]  pr0_q, pr1_q, pr2_q, pr3_q;
  logic signed [ACC_W-1:0]   r_q, q_q, s_d, s_q;
  logic signed [HI_W-1:0]    hi;
  logic signed [COORD_W-1:0] point_d, point_q;

  assign pr0_d = $signed({1'b0, weights_i.w0}) * p0_i;
  assign pr1_d = $signed({1'b0, weights_i.w1}) * p1_i;
  assign pr2_d = $signed({1'b0, weights_i.w2}) * p2_i;
  assign pr3_d = $signed({1'b0, weights_i.w3}) * p3_i;

  // The middle pair carries the factor 3 of the Bernstein basis.
  assign s_d = r_q + q_q + (q_q <<< 1) + ROUND_HALF;

  always_comb begin
    hi = s_q[ACC_W-1:W_FRAC];
    if (hi > HI_MAX) begin
      point_d = HI_MAX[COORD_W-1:0];
    end else if (hi < HI_MIN) begin
      point_d = HI_MIN[COORD_W-1:0];
    end else begin
      point_d = hi[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s4_en) begin
      pr0_q <= pr0_d;
      pr1_q <= pr1_d;
      pr2_q <= pr2_d;
      pr3_q <= pr3_d;
    end
    if (ctrl_i.s5_en) begin
      r_q <= ACC_W'(pr0_q) + ACC_W'(pr3_q);
      q_q <= ACC_W'(pr1_q) + ACC_W'(pr2_q);
    end
    if (ctrl_i.s6_en) begin
      s_q <= s_d;
    end
    if (ctrl_i.s7_en) begin
      point_q <= point_d;
    end
  end

  assign point_o = point_q;

endmodule

>>> rtl/cubic_bezier_point_eval.sv
// Throughput: one word per cycle while the output is not stalled; the seven-stage pipeline
// of multipliers and adders sets it.
// A stalled output holds its stage, and bubbles in earlier stages still fill behind it.
// Reset clears all stage valid bits and loads the control points with their defaults.
// Top level: control point registers, pipeline valid and enable chain, two blend lanes.
module cubic_bezier_point_eval (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [cbpe_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [cbpe_pkg::COORD_W-1:0]           cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [cbpe_pkg::STEP_W-1:0]            step_index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [cbpe_pkg::COORD_W-1:0]    point_x_o,
  output logic signed [cbpe_pkg::COORD_W-1:0]    point_y_o,
  output logic                                   last_point_o
);
  import cbpe_pkg::*;

  logic [COORD_W-1:0] p0_x_q, p0_y_q, p1_x_q, p1_y_q;
  logic [COORD_W-1:0] p2_x_q, p2_y_q, p3_x_q, p3_y_q;

  logic [PIPE_DEPTH-1:0] v_q, last_q, en;
  logic                  last_d;
  weight_ctrl_t          wctrl;
  blend_ctrl_t           bctrl;
  weights_t              weights;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_x_q <= P0_X_RST;
      p0_y_q <= P0_Y_RST;
      p1_x_q <= P1_X_RST;
      p1_y_q <= P1_Y_RST;
      p2_x_q <= P2_X_RST;
      p2_y_q <= P2_Y_RST;
      p3_x_q <= P3_X_RST;
      p3_y_q <= P3_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_P0_X: p0_x_q <= cfg_data_i;
        REG_P0_Y: p0_y_q <= cfg_data_i;
        REG_P1_X: p1_x_q <= cfg_data_i;
        REG_P1_Y: p1_y_q <= cfg_data_i;
        REG_P2_X: p2_x_q <= cfg_data_i;
        REG_P2_Y: p2_y_q <= cfg_data_i;
        REG_P3_X: p3_x_q <= cfg_data_i;
        REG_P3_Y: p3_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[PIPE_DEPTH-1] = !v_q[PIPE_DEPTH-1] || !out_stall_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];
  assign last_d     = step_index_i >= STEP_W'(SEGMENTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      last_q[0] <= last_d;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  always_comb begin
    wctrl.s1_en = en[0];
    wctrl.s2_en = en[1];
    wctrl.s3_en = en[2];
    bctrl.s4_en = en[3];
    bctrl.s5_en = en[4];
    bctrl.s6_en = en[5];
    bctrl.s7_en = en[6];
  end

  cbpe_weight u_weight (
    .clk_i        (clk_i),
    .ctrl_i       (wctrl),
    .step_index_i (step_index_i),
    .weights_o    (weights)
  );

  cbpe_blend u_blend_x (
    .clk_i     (clk_i),
    .ctrl_i    (bctrl),
    .weights_i (weights),
    .p0_i      ($signed(p0_x_q)),
    .p1_i      ($signed(p1_x_q)),
    .p2_i      ($signed(p2_x_q)),
    .p3_i      ($signed(p3_x_q)),
    .point_o   (point_x_o)
  );

  cbpe_blend u_blend_y (
    .clk_i     (clk_i),
    .ctrl_i    (bctrl),
    .weights_i (weights),
    .p0_i      ($signed(p0_y_q)),
    .p1_i      ($signed(p1_y_q)),
    .p2_i      ($signed(p2_y_q)),
    .p3_i      ($signed(p3_y_q)),
    .point_o   (point_y_o)
  );

  assign out_valid_o  = v_q[PIPE_DEPTH-1];
  assign last_point_o = last_q[PIPE_DEPTH-1];

endmodule

>>> rtl/cbpe_checker.sv
// Port-level assertions for the Bezier point evaluator and the bind that attaches them.
module cbpe_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic signed [cbpe_pkg::COORD_W-1:0] point_x_o,
  input  logic signed [cbpe_pkg::COORD_W-1:0] point_y_o,
  input  logic                                last_point_o
);
  import cbpe_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Words accepted at the input whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - CNT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_x_o)
      && $stable(point_y_o) && $stable(last_point_o))
    else $error("stalled output word changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("output word without a matching input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == CNT_W'(PIPE_DEPTH)) && !out_acc |-> in_stall_o)
    else $error("input accepted beyond pipeline depth");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == '0 |-> !in_stall_o)
    else $error("empty pipeline stalls its input");

endmodule

bind cubic_bezier_point_eval cbpe_checker u_cbpe_checker (.*);
